// ----- hw/rtl/pssh_pkg.sv -----
// ----------------------------------------------------------------------------
// pssh_pkg
// Shared constants, types and helper functions of the partition/slot size
// histogram: table geometry, field widths, request and register codes.
// ----------------------------------------------------------------------------
package pssh_pkg;

  // table geometry
  localparam int MAX_PARTITIONS = 16;
  localparam int MAX_SLOTS      = 256;
  localparam int TABLE_DEPTH    = MAX_PARTITIONS * MAX_SLOTS;
  localparam int PART_W         = $clog2(MAX_PARTITIONS);
  localparam int SLOT_W         = $clog2(MAX_SLOTS);
  localparam int ADDR_W         = PART_W + SLOT_W;
  localparam int NP_W           = $clog2(MAX_PARTITIONS + 1);
  localparam int NS_W           = $clog2(MAX_SLOTS + 1);

  // field widths
  localparam int REQ_W      = 2;
  localparam int HASH_W     = 64;
  localparam int BUCKET_W   = 32;
  localparam int LEN_W      = 16;
  localparam int VALUE_W    = 48;
  localparam int COUNT_W    = 32;
  localparam int PCOUNT_W   = 5;
  localparam int SCOUNT_W   = 9;

  // configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] CFG_BUCKET_COUNT    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PARTITION_COUNT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SLOT_COUNT      = 2'd2;

  localparam logic [BUCKET_W-1:0] BUCKET_COUNT_RESET    = 32'd16;
  localparam logic [PCOUNT_W-1:0] PARTITION_COUNT_RESET = 5'd1;
  localparam logic [SCOUNT_W-1:0] SLOT_COUNT_RESET      = 9'd256;

  // request codes
  localparam logic [REQ_W-1:0] REQ_COUNT   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CONVERT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ    = 2'd2;

  // bytes added per record on top of key and value
  localparam int RECORD_OVERHEAD = 2;

  // mapping settings seen by the mapper
  typedef struct packed {
    logic [BUCKET_W-1:0] bucket_count;
    logic [NP_W-1:0]     parts;
    logic [NS_W-1:0]     slots;
  } map_cfg_t;

  // mapper status toward the top level
  typedef struct packed {
    logic              done;
    logic [PART_W-1:0] part;
    logic [SLOT_W-1:0] slot;
  } map_result_t;

  // partitions in use: zero counts as one, clamp to table size
  function automatic logic [NP_W-1:0] parts_in_use(input logic [PCOUNT_W-1:0] pc);
    logic [NP_W-1:0] r;
    if (pc == '0) begin
      r = NP_W'(1);
    end else if (int'(pc) > MAX_PARTITIONS) begin
      r = NP_W'(MAX_PARTITIONS);
    end else begin
      r = NP_W'(pc);
    end
    return r;
  endfunction

  // slots in use: zero counts as one, clamp to table size
  function automatic logic [NS_W-1:0] slots_in_use(input logic [SCOUNT_W-1:0] sc);
    logic [NS_W-1:0] r;
    if (sc == '0) begin
      r = NS_W'(1);
    end else if (int'(sc) > MAX_SLOTS) begin
      r = NS_W'(MAX_SLOTS);
    end else begin
      r = NS_W'(sc);
    end
    return r;
  endfunction

  function automatic logic [VALUE_W-1:0] add_sat_value(input logic [VALUE_W-1:0] a,
                                                       input logic [VALUE_W-1:0] b);
    logic [VALUE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[VALUE_W] ? {VALUE_W{1'b1}} : s[VALUE_W-1:0];
  endfunction

  function automatic logic [COUNT_W-1:0] add_sat_count(input logic [COUNT_W-1:0] a,
                                                       input logic [COUNT_W-1:0] b);
    logic [COUNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COUNT_W] ? {COUNT_W{1'b1}} : s[COUNT_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/pssh_if.sv -----
// ----------------------------------------------------------------------------
// pssh_if
// Valid/ready channels of the histogram: request, response and register
// write channel.
// ----------------------------------------------------------------------------

// request channel
interface pssh_req_if;
  import pssh_pkg::*;
  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic [HASH_W-1:0]   hash_value;
  logic [BUCKET_W-1:0] bucket_num;
  logic [LEN_W-1:0]    key_length;
  logic [LEN_W-1:0]    value_length;
  logic [PART_W-1:0]   partition_select;
  logic [SLOT_W-1:0]   slot_select;

  modport source (output valid, req_type, hash_value, bucket_num, key_length,
                  value_length, partition_select, slot_select, input ready);
  modport sink (input valid, req_type, hash_value, bucket_num, key_length,
                value_length, partition_select, slot_select, output ready);
endinterface

// response channel
interface pssh_rsp_if;
  import pssh_pkg::*;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] result_value;
  logic [COUNT_W-1:0] record_count;
  logic [PART_W-1:0]  partition_out;
  logic [SLOT_W-1:0]  slot_out;

  modport source (output valid, result_value, record_count, partition_out, slot_out,
                  input ready);
  modport sink (input valid, result_value, record_count, partition_out, slot_out,
                output ready);
endinterface

// register write channel
interface pssh_cfg_if;
  import pssh_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/pssh_ram.sv -----
// ----------------------------------------------------------------------------
// pssh_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pssh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/pssh_map.sv -----
// ----------------------------------------------------------------------------
// pssh_map
// Bit-serial record mapper. A restoring divider computes
// bucket_count / partitions in the first 32 steps and bucket_num / that
// quotient in the next 32; alongside, a 9-bit remainder unit reduces the
// 64-bit hash modulo the slots in use one bit per step. 64 steps in all.
// ----------------------------------------------------------------------------
module pssh_map (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  pssh_pkg::map_cfg_t            cfg,
  input  logic [pssh_pkg::HASH_W-1:0]   hash_value,
  input  logic [pssh_pkg::BUCKET_W-1:0] bucket_num,
  output pssh_pkg::map_result_t         result
);
  import pssh_pkg::*;

  localparam int STEP_W = $clog2(HASH_W);
  localparam logic [STEP_W-1:0] LAST_STEP   = STEP_W'(HASH_W - 1);
  localparam logic [STEP_W-1:0] SWITCH_STEP = STEP_W'(BUCKET_W - 1);

  logic                busy;
  logic [STEP_W-1:0]   step;
  logic                done;
  logic [PART_W-1:0]   part;
  logic [SLOT_W-1:0]   slot;

  logic [BUCKET_W-1:0] dvd;
  logic [BUCKET_W-1:0] dsr;
  logic [BUCKET_W-1:0] rem;
  logic [BUCKET_W-1:0] bkt;
  logic                div_zero;
  logic [HASH_W-1:0]   hsh;
  logic [NS_W-1:0]     hrem;

  logic [BUCKET_W:0]   trial;
  logic [BUCKET_W:0]   trial_diff;
  logic                fits;
  logic [BUCKET_W-1:0] rem_next;
  logic [BUCKET_W-1:0] quo_next;
  logic [NS_W:0]       htrial;
  logic [NS_W:0]       hdiff;
  logic                hfits;
  logic [NS_W-1:0]     hrem_next;
  logic [NP_W-1:0]     last_part;
  logic [PART_W-1:0]   part_next;

  // one restoring step of the divider
  always_comb begin
    trial      = {rem, dvd[BUCKET_W-1]};
    trial_diff = trial - {1'b0, dsr};
    fits       = trial >= {1'b0, dsr};
    rem_next   = fits ? trial_diff[BUCKET_W-1:0] : trial[BUCKET_W-1:0];
    quo_next   = {dvd[BUCKET_W-2:0], fits};
  end

  // one step of the hash remainder
  always_comb begin
    htrial    = {hrem, hsh[HASH_W-1]};
    hdiff     = htrial - {1'b0, cfg.slots};
    hfits     = htrial >= {1'b0, cfg.slots};
    hrem_next = hfits ? hdiff[NS_W-1:0] : htrial[NS_W-1:0];
  end

  // zero divisor or quotient past the end selects the last partition
  always_comb begin
    last_part = cfg.parts - NP_W'(1);
    if (div_zero || (quo_next >= BUCKET_W'(cfg.parts))) begin
      part_next = last_part[PART_W-1:0];
    end else begin
      part_next = quo_next[PART_W-1:0];
    end
  end

  // step sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shift registers and remainders
  always_ff @(posedge clk) begin
    if (start) begin
      dvd  <= cfg.bucket_count;
      dsr  <= BUCKET_W'(cfg.parts);
      rem  <= '0;
      bkt  <= bucket_num;
      hsh  <= hash_value;
      hrem <= '0;
    end else if (busy) begin
      hsh  <= hsh << 1;
      hrem <= hrem_next;
      if (step == SWITCH_STEP) begin
        // divisor ready: start dividing the bucket number by it
        dvd      <= bkt;
        dsr      <= quo_next;
        rem      <= '0;
        div_zero <= (quo_next == '0);
      end else begin
        dvd <= quo_next;
        rem <= rem_next;
      end
      if (step == LAST_STEP) begin
        part <= part_next;
        slot <= hrem_next[SLOT_W-1:0];
      end
    end
  end

  assign result = '{done: done, part: part, slot: slot};

endmodule

// ----- hw/rtl/partition_slot_size_histogram.sv -----
// ----------------------------------------------------------------------------
// partition_slot_size_histogram
// Partition-by-slot table of saturating byte totals and record counts with
// count, convert-to-offsets and read requests.
// ----------------------------------------------------------------------------
// After reset the block sweeps both tables to zero, one entry per cycle, over
// all 4096 entries; requests wait until the sweep is done, register writes are
// taken at any time. One request is worked on at a time. A count request runs
// through the 64-step bit-serial divider and hash remainder in the mapper,
// then a read and a write of the table. A read request reads the addressed
// entry. A convert request walks the slots in use of the selected partition
// through the single table read port, one slot per cycle. A finished result
// sits in an output register, so the next request can be taken while the
// result waits for the consumer.
// ----------------------------------------------------------------------------
module partition_slot_size_histogram (
  input logic       clk,
  input logic       rst,
  pssh_cfg_if.sink  cfg,
  pssh_req_if.sink  req,
  pssh_rsp_if.source rsp
);
  import pssh_pkg::*;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_MAP    = 3'd2;
  localparam logic [2:0] ST_READ   = 3'd3;
  localparam logic [2:0] ST_UPDATE = 3'd4;
  localparam logic [2:0] ST_CONV   = 3'd5;
  localparam logic [2:0] ST_FIN    = 3'd6;

  logic [2:0]          state;
  logic [ADDR_W-1:0]   clr_addr;

  // registers
  logic [BUCKET_W-1:0] bucket_count;
  logic [PCOUNT_W-1:0] partition_count;
  logic [SCOUNT_W-1:0] slot_count;
  logic [NS_W-1:0]     slots;
  map_cfg_t            map_cfg;
  map_result_t         map_res;

  // held request
  logic                accept;
  logic [REQ_W-1:0]    kind;
  logic [LEN_W-1:0]    key_len;
  logic [LEN_W-1:0]    val_len;
  logic [PART_W-1:0]   psel;
  logic [ADDR_W-1:0]   addr;

  // convert walk
  logic [NS_W-1:0]     idx;
  logic [SLOT_W-1:0]   widx;
  logic                pend;
  logic                rd_issue;
  logic [VALUE_W-1:0]  off;
  logic [COUNT_W-1:0]  csum;

  // result staging and output register
  logic [VALUE_W-1:0]  res_value;
  logic [COUNT_W-1:0]  res_count;
  logic [PART_W-1:0]   res_part;
  logic [SLOT_W-1:0]   res_slot;
  logic                out_valid;
  logic                out_free;
  logic [VALUE_W-1:0]  out_value;
  logic [COUNT_W-1:0]  out_count;
  logic [PART_W-1:0]   out_part;
  logic [SLOT_W-1:0]   out_slot;

  // table ports
  logic                val_we;
  logic                cnt_we;
  logic [ADDR_W-1:0]   waddr;
  logic [ADDR_W-1:0]   raddr;
  logic [VALUE_W-1:0]  val_wdata;
  logic [COUNT_W-1:0]  cnt_wdata;
  logic [VALUE_W-1:0]  val_rdata;
  logic [COUNT_W-1:0]  cnt_rdata;
  logic [VALUE_W-1:0]  new_value;
  logic [COUNT_W-1:0]  new_count;

  // register writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count    <= BUCKET_COUNT_RESET;
      partition_count <= PARTITION_COUNT_RESET;
      slot_count      <= SLOT_COUNT_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_BUCKET_COUNT:    bucket_count    <= cfg.data[BUCKET_W-1:0];
        CFG_PARTITION_COUNT: partition_count <= cfg.data[PCOUNT_W-1:0];
        CFG_SLOT_COUNT:      slot_count      <= cfg.data[SCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign slots   = slots_in_use(slot_count);
  assign map_cfg = '{bucket_count: bucket_count,
                     parts: parts_in_use(partition_count),
                     slots: slots};

  // request transfer
  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;

  pssh_map u_map (
    .clk        (clk),
    .rst        (rst),
    .start      (accept && (req.req_type == REQ_COUNT)),
    .cfg        (map_cfg),
    .hash_value (req.hash_value),
    .bucket_num (req.bucket_num),
    .result     (map_res)
  );

  // entry update for a count request
  assign new_value = add_sat_value(val_rdata, VALUE_W'(key_len) + VALUE_W'(val_len)
                                              + VALUE_W'(RECORD_OVERHEAD));
  assign new_count = add_sat_count(cnt_rdata, COUNT_W'(1));

  assign rd_issue = (state == ST_CONV) && (idx < slots);
  assign out_free = !out_valid || rsp.ready;

  // table port selection
  always_comb begin
    val_we    = 1'b0;
    cnt_we    = 1'b0;
    waddr     = addr;
    raddr     = addr;
    val_wdata = new_value;
    cnt_wdata = new_count;
    case (state)
      ST_CLEAR: begin
        val_we    = 1'b1;
        cnt_we    = 1'b1;
        waddr     = clr_addr;
        val_wdata = '0;
        cnt_wdata = '0;
      end
      ST_UPDATE: begin
        if (kind == REQ_COUNT) begin
          val_we = 1'b1;
          cnt_we = 1'b1;
        end
      end
      ST_CONV: begin
        raddr = {psel, idx[SLOT_W-1:0]};
        if (pend) begin
          val_we    = 1'b1;
          waddr     = {psel, widx};
          val_wdata = off;
        end
      end
      default: ;
    endcase
  end

  pssh_ram #(.WIDTH(VALUE_W), .DEPTH(TABLE_DEPTH)) u_value_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (waddr),
    .wdata (val_wdata),
    .raddr (raddr),
    .rdata (val_rdata)
  );

  pssh_ram #(.WIDTH(COUNT_W), .DEPTH(TABLE_DEPTH)) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (waddr),
    .wdata (cnt_wdata),
    .raddr (raddr),
    .rdata (cnt_rdata)
  );

  // control state machine
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && (state != ST_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(TABLE_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            case (req.req_type)
              REQ_COUNT:   state <= ST_MAP;
              REQ_CONVERT: state <= ST_CONV;
              REQ_READ:    state <= ST_READ;
              default:     state <= ST_FIN;
            endcase
          end
        end
        ST_MAP: begin
          if (map_res.done) begin
            state <= ST_READ;
          end
        end
        ST_READ:   state <= ST_UPDATE;
        ST_UPDATE: state <= ST_FIN;
        ST_CONV: begin
          if (!rd_issue && !pend) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          // a result leaving in this cycle makes room for the next one
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end else if (out_valid && rsp.ready) begin
            out_valid <= 1'b0;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // request capture, convert walk and results
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          kind      <= req.req_type;
          key_len   <= req.key_length;
          val_len   <= req.value_length;
          psel      <= req.partition_select;
          addr      <= {req.partition_select, req.slot_select};
          idx       <= '0;
          pend      <= 1'b0;
          off       <= '0;
          csum      <= '0;
          res_value <= '0;
          res_count <= '0;
          res_part  <= (req.req_type == REQ_CONVERT || req.req_type == REQ_READ)
                       ? req.partition_select : '0;
          res_slot  <= (req.req_type == REQ_READ) ? req.slot_select : '0;
        end
      end
      ST_MAP: begin
        if (map_res.done) begin
          addr     <= {map_res.part, map_res.slot};
          res_part <= map_res.part;
          res_slot <= map_res.slot;
        end
      end
      ST_UPDATE: begin
        if (kind == REQ_COUNT) begin
          res_value <= new_value;
          res_count <= new_count;
        end else begin
          res_value <= val_rdata;
          res_count <= cnt_rdata;
        end
      end
      ST_CONV: begin
        // read slot idx now, store its offset when the data returns
        if (rd_issue) begin
          idx  <= idx + NS_W'(1);
          widx <= idx[SLOT_W-1:0];
        end
        pend <= rd_issue;
        if (pend) begin
          off  <= add_sat_value(off, val_rdata);
          csum <= add_sat_count(csum, cnt_rdata);
        end
        if (!rd_issue && !pend) begin
          res_value <= off;
          res_count <= csum;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_value <= res_value;
          out_count <= res_count;
          out_part  <= res_part;
          out_slot  <= res_slot;
        end
      end
      default: ;
    endcase
  end

  // response channel
  assign rsp.valid         = out_valid;
  assign rsp.result_value  = out_value;
  assign rsp.record_count  = out_count;
  assign rsp.partition_out = out_part;
  assign rsp.slot_out      = out_slot;

endmodule

// ----- hw/rtl/pssh_check.sv -----
// ----------------------------------------------------------------------------
// pssh_check
// Port-level checks of the histogram: clearing after reset, bound on
// requests in flight, no response without a request, stalled response holds.
// ----------------------------------------------------------------------------
module pssh_check (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [pssh_pkg::VALUE_W-1:0] result_value,
  input logic [pssh_pkg::COUNT_W-1:0] record_count,
  input logic [pssh_pkg::PART_W-1:0]  partition_out,
  input logic [pssh_pkg::SLOT_W-1:0]  slot_out
);
  import pssh_pkg::*;

  logic [1:0] in_flight;

  // requests taken but not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= '0;
    end else begin
      in_flight <= in_flight + 2'(req_valid && req_ready) - 2'(rsp_valid && rsp_ready);
    end
  end

  // table sweep blocks requests right after reset
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !req_ready)
    else $error("request taken during table clearing");

  // one request in work plus one waiting result at most
  a_in_flight_bound: assert property (@(posedge clk) disable iff (rst)
    in_flight != 2'd3)
    else $error("more than two requests in flight");

  // every response answers a request
  a_rsp_has_req: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> in_flight != 2'd0)
    else $error("response without request");

  // stalled response keeps its contents
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(result_value)
      && $stable(record_count) && $stable(partition_out) && $stable(slot_out))
    else $error("stalled response changed");

endmodule

bind partition_slot_size_histogram pssh_check u_pssh_check (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .result_value  (rsp.result_value),
  .record_count  (rsp.record_count),
  .partition_out (rsp.partition_out),
  .slot_out      (rsp.slot_out)
);
